[hw/rtl/mpsg_pkg.sv]
// Package for the midpoint subdivision gradient unit.
// Holds widths, stage count, color and pipeline stage types, and the midpoint color function.
// No dependencies.
package mpsg_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int POS_W      = $clog2(MAX_LENGTH);
  localparam int LEN_W      = POS_W + 1;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 4 * CH_W;
  localparam int CFG_IDX_W  = 2;
  // Each step at least halves the interval, so POS_W steps reach adjacent positions.
  localparam int N_STEPS    = POS_W;
  localparam int NUM_STAGES = N_STEPS + 1;
  localparam int CNT_W      = $clog2(NUM_STAGES + 1);

  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LENGTH);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);
  localparam logic [CH_W-1:0]  ALPHA_MID = {CH_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_COLOR = 2'd0,
    CFG_END_COLOR   = 2'd1,
    CFG_LINE_LENGTH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    color_t           lo_color;
    color_t           hi_color;
    color_t           color;
    logic             done;
    logic             oor;
  } stage_t;

  // Per-channel truncated average, alpha forced opaque.
  function automatic color_t mid_color(color_t a, color_t b);
    logic [CH_W:0] r;
    logic [CH_W:0] g;
    logic [CH_W:0] bl;
    color_t        c;
    r  = {1'b0, a.red}   + {1'b0, b.red};
    g  = {1'b0, a.green} + {1'b0, b.green};
    bl = {1'b0, a.blue}  + {1'b0, b.blue};
    c.alpha = ALPHA_MID;
    c.red   = r[CH_W:1];
    c.green = g[CH_W:1];
    c.blue  = bl[CH_W:1];
    return c;
  endfunction

endpackage

[hw/rtl/mpsg_if.sv]
// Channel interfaces of the midpoint subdivision gradient unit: position in, color out, config.
// Depends on mpsg_pkg.
interface mpsg_in_if;
  import mpsg_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface mpsg_out_if;
  import mpsg_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha;
  logic            out_of_range;
  modport source (output valid, output red, output green, output blue, output alpha,
                  output out_of_range, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input out_of_range, output ready);
endinterface

interface mpsg_cfg_if;
  import mpsg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/mpsg_step.sv]
// One subdivision step of the gradient pipeline, with its own stage register.
// Depends on mpsg_pkg.
module mpsg_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  mpsg_pkg::stage_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output mpsg_pkg::stage_t data_o
);
  import mpsg_pkg::*;

  logic             valid_q;
  stage_t           data_q;
  stage_t           data_d;
  logic [POS_W:0]   sum;
  logic [POS_W-1:0] mid;
  color_t           mid_c;

  always_comb begin
    data_d = data_i;
    sum    = {1'b0, data_i.lo} + {1'b0, data_i.hi};
    mid    = sum[POS_W:1];
    mid_c  = mid_color(data_i.lo_color, data_i.hi_color);
    if (!data_i.done) begin
      if (data_i.pos == mid) begin
        data_d.done  = 1'b1;
        data_d.color = mid_c;
      end else if (data_i.pos < mid) begin
        data_d.hi       = mid;
        data_d.hi_color = mid_c;
      end else begin
        data_d.lo       = mid;
        data_d.lo_color = mid_c;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/midpoint_subdivision_gradient_unit.sv]
// Midpoint subdivision gradient unit: top level.
// Depends on mpsg_pkg, the mpsg_*_if interfaces and mpsg_step.
//
// Returns the color at one position of a gradient line built by recursive
// midpoint subdivision between a start and an end color. Position 0 gives the
// start color and position length-1 the end color, each with its own alpha;
// every other position gets the color of the subdivision midpoint that lands
// on it, alpha 255. A position at or past the line length returns all-zero
// channels with out_of_range set. The line length register is clamped to
// 2..4096. The unit is a pipeline of 13 register stages: one entry stage that
// checks range and endpoints, then 12 stages that each take one halving step
// of the interval. One position is taken per cycle unless back-pressure stalls
// the input. Each result passes through the entry register and all 12 step
// registers before it shows on the output.
// Each stage holds its own valid bit and stalls only when its successor is full,
// so back-pressure on the output fills bubbles before halting the input.
// Configuration writes are always accepted (ready is always high) and must
// only occur while no position is in flight; an index of 3 is ignored.
module midpoint_subdivision_gradient_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  mpsg_cfg_if.sink          cfg_i,
  mpsg_in_if.sink           in_i,
  mpsg_out_if.source        out_o
);
  import mpsg_pkg::*;

  // Configuration registers
  color_t           start_color_q;
  color_t           end_color_q;
  logic [LEN_W-1:0] line_length_q;

  // Pipeline stage signals; stage 0 is the entry stage, 1..N_STEPS are steps.
  logic             valid_s [NUM_STAGES];
  stage_t           data_s  [NUM_STAGES];
  logic             ready_s [NUM_STAGES+1];

  logic             entry_valid_q;
  stage_t           entry_q;
  stage_t           entry_d;

  logic [LEN_W-1:0] len_eff;
  logic [POS_W-1:0] last_pos;
  logic             is_oor;
  logic             is_first;
  logic             is_last;

  // Configuration port: always ready, decode the index.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_color_q <= '0;
      end_color_q   <= '1;
      line_length_q <= LEN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_START_COLOR: start_color_q <= cfg_i.data;
        CFG_END_COLOR:   end_color_q   <= cfg_i.data;
        CFG_LINE_LENGTH: line_length_q <= cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry stage: clamp the length, flag out-of-range, resolve endpoints.
  always_comb begin
    if (line_length_q < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (line_length_q > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = line_length_q;
    end
    last_pos = POS_W'(len_eff - LEN_W'(1));
    is_oor   = {1'b0, in_i.position} >= len_eff;
    is_first = in_i.position == '0;
    is_last  = in_i.position == last_pos;

    entry_d.pos      = in_i.position;
    entry_d.lo       = '0;
    entry_d.hi       = last_pos;
    entry_d.lo_color = start_color_q;
    entry_d.hi_color = end_color_q;
    entry_d.oor      = is_oor;
    entry_d.done     = is_oor || is_first || is_last;
    if (is_oor) begin
      entry_d.color = '0;
    end else if (is_first) begin
      entry_d.color = start_color_q;
    end else if (is_last) begin
      entry_d.color = end_color_q;
    end else begin
      entry_d.color = '0;
    end
  end

  // Advance the entry stage whenever it is empty or its successor takes it.
  assign ready_s[0] = !entry_valid_q || ready_s[1];
  assign in_i.ready = ready_s[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (ready_s[0]) begin
      entry_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_s[0] && in_i.valid) begin
      entry_q <= entry_d;
    end
  end

  assign valid_s[0] = entry_valid_q;
  assign data_s[0]  = entry_q;

  // Subdivision steps: each halves the interval around the position.
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_step
    mpsg_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k-1]),
      .ready_o (ready_s[k]),
      .data_i  (data_s[k-1]),
      .valid_o (valid_s[k]),
      .ready_i (ready_s[k+1]),
      .data_o  (data_s[k])
    );
  end

  // Output: the last stage register drives the result channel directly.
  assign ready_s[NUM_STAGES] = out_o.ready;
  assign out_o.valid         = valid_s[NUM_STAGES-1];
  assign out_o.red           = data_s[NUM_STAGES-1].color.red;
  assign out_o.green         = data_s[NUM_STAGES-1].color.green;
  assign out_o.blue          = data_s[NUM_STAGES-1].color.blue;
  assign out_o.alpha         = data_s[NUM_STAGES-1].color.alpha;
  assign out_o.out_of_range  = data_s[NUM_STAGES-1].oor;

endmodule

[hw/rtl/mpsg_checker.sv]
// Port-level checker for the midpoint subdivision gradient unit, bound to the top level.
// Depends on mpsg_pkg.
module mpsg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [mpsg_pkg::CH_W-1:0] red_i,
  input logic [mpsg_pkg::CH_W-1:0] green_i,
  input logic [mpsg_pkg::CH_W-1:0] blue_i,
  input logic [mpsg_pkg::CH_W-1:0] alpha_i,
  input logic                      out_of_range_i
);
  import mpsg_pkg::*;

  logic             in_xfer;
  logic             out_xfer;
  logic [CNT_W-1:0] in_flight_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      in_flight_q <= in_flight_q + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      in_flight_q <= in_flight_q - CNT_W'(1);
    end
  end

  // An out-of-range result carries all-zero channels.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_range_i |->
      red_i == '0 && green_i == '0 && blue_i == '0 && alpha_i == '0)
    else $error("out_of_range result with nonzero color");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i) &&
      $stable(alpha_i) && $stable(out_of_range_i))
    else $error("stalled result changed");

  // No result without an earlier accepted position.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> in_flight_q != '0)
    else $error("result transfer with nothing in flight");

  // Occupancy never exceeds the pipeline depth.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight_q <= CNT_W'(NUM_STAGES))
    else $error("more items in flight than pipeline stages");

endmodule

bind midpoint_subdivision_gradient_unit mpsg_checker u_mpsg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .red_i          (out_o.red),
  .green_i        (out_o.green),
  .blue_i         (out_o.blue),
  .alpha_i        (out_o.alpha),
  .out_of_range_i (out_o.out_of_range)
);

[tb/midpoint_subdivision_gradient_unit_test.sv]
// Self-checking testbench for midpoint_subdivision_gradient_unit.
// Depends on mpsg_pkg, the mpsg_*_if interfaces and the unit's RTL.
// Predicts each color by walking the subdivision tree and checks results in order.
module midpoint_subdivision_gradient_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpsg_pkg::*;

  // Register index with no register behind it; the unit drops writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT    = 2000;
  // Length of the long receiver hold-off that fills the pipeline.
  localparam int HOLD_CYCLES    = 100;
  // Pipeline depth is 13 stages; allow some margin when settling.
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 85;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            oor;
  } shade_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    shade_t           shade;
  } pending_shade_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  // Scoreboard: keeps its own copy of the registers, predicts the color of
  // every accepted position and checks returned colors in order.
  class gradient_color_board;
    color_t           first_color;
    color_t           last_color;
    logic [LEN_W-1:0] span_len;
    pending_shade_t   pending_colors[$];
    int               errors;

    function new();
      first_color = '0;
      last_color  = '1;
      span_len    = LEN_RESET;
      errors      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
      case (idx)
        CFG_START_COLOR: first_color = value;
        CFG_END_COLOR:   last_color  = value;
        CFG_LINE_LENGTH: span_len    = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned effective_length();
      int unsigned n;
      n = span_len;
      if (n < LEN_MIN) n = LEN_MIN;
      if (n > MAX_LENGTH) n = MAX_LENGTH;
      return n;
    endfunction

    function color_t halfway(color_t a, color_t b);
      color_t c;
      c.alpha = ALPHA_MID;
      c.red   = CH_W'((int'(a.red) + int'(b.red)) / 2);
      c.green = CH_W'((int'(a.green) + int'(b.green)) / 2);
      c.blue  = CH_W'((int'(a.blue) + int'(b.blue)) / 2);
      return c;
    endfunction

    // Narrow the interval around pos until pos lands on a midpoint.
    function shade_t color_at_position(logic [POS_W-1:0] pos);
      int unsigned len, lo, hi, m;
      color_t      c_lo, c_hi, c_mid, pick;
      shade_t      s;
      len = effective_length();
      s = '0;
      if (pos >= len) begin
        s.oor = 1'b1;
        return s;
      end
      lo   = 0;
      hi   = len - 1;
      c_lo = first_color;
      c_hi = last_color;
      pick = '0;
      if (pos == lo) begin
        pick = c_lo;
      end else if (pos == hi) begin
        pick = c_hi;
      end else begin
        while (hi - lo > 1) begin
          m     = (lo + hi) / 2;
          c_mid = halfway(c_lo, c_hi);
          if (pos == m) begin
            pick = c_mid;
            break;
          end
          if (pos < m) begin
            hi   = m;
            c_hi = c_mid;
          end else begin
            lo   = m;
            c_lo = c_mid;
          end
        end
      end
      s.red   = pick.red;
      s.green = pick.green;
      s.blue  = pick.blue;
      s.alpha = pick.alpha;
      return s;
    endfunction

    function void note_position(logic [POS_W-1:0] pos);
      pending_shade_t p;
      p.pos   = pos;
      p.shade = color_at_position(pos);
      pending_colors.push_back(p);
    endfunction

    function int pending();
      return pending_colors.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH: %s", msg);
    endtask

    task check_color(shade_t got);
      pending_shade_t want;
      if (pending_colors.size() == 0) begin
        report_mismatch("color returned with no position waiting");
        return;
      end
      want = pending_colors.pop_front();
      if (got.red !== want.shade.red)
        report_mismatch($sformatf("pos %0d red %02h, predicted %02h",
                                  want.pos, got.red, want.shade.red));
      if (got.green !== want.shade.green)
        report_mismatch($sformatf("pos %0d green %02h, predicted %02h",
                                  want.pos, got.green, want.shade.green));
      if (got.blue !== want.shade.blue)
        report_mismatch($sformatf("pos %0d blue %02h, predicted %02h",
                                  want.pos, got.blue, want.shade.blue));
      if (got.alpha !== want.shade.alpha)
        report_mismatch($sformatf("pos %0d alpha %02h, predicted %02h",
                                  want.pos, got.alpha, want.shade.alpha));
      if (got.oor !== want.shade.oor)
        report_mismatch($sformatf("pos %0d out_of_range %b, predicted %b",
                                  want.pos, got.oor, want.shade.oor));
    endtask

    task check_leftover();
      if (pending_colors.size() != 0)
        report_mismatch($sformatf("%0d colors never returned", pending_colors.size()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  mpsg_cfg_if cfg_ch ();
  mpsg_in_if  in_ch ();
  mpsg_out_if out_ch ();

  midpoint_subdivision_gradient_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  gradient_color_board board = new();

  // Receiver controls, owned by the main sequence and read by the receiver.
  rx_mode_e    rx_mode       = RX_FREE;
  logic [15:0] rx_pattern    = 16'hFFFF;
  int unsigned stall_pct     = 0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          idle_cycles   = 0;

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Every input gets a known value at time zero.
  initial begin
    rst_ni         = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    in_ch.valid    = 1'b0;
    in_ch.position = '0;
  end

  // ---------------------------------------------------------------------------
  // Monitors: sample at the rising edge, where a transfer happens.
  // ---------------------------------------------------------------------------

  // Register writes update the predictor's copy at the same edge as the unit.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_ch.valid && cfg_ch.ready)
      board.write_register(cfg_ch.index, cfg_ch.data);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      board.note_position(in_ch.position);
  end

  always @(posedge clk_i) begin : color_monitor
    shade_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.red   = out_ch.red;
      got.green = out_ch.green;
      got.blue  = out_ch.blue;
      got.alpha = out_ch.alpha;
      got.oor   = out_ch.out_of_range;
      board.check_color(got);
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drives ready at the falling edge. Free-running, random stalls
  // or a rotating pattern, plus a long hold-off on request that backs the
  // pipeline up until the input stalls.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        case (rx_mode)
          RX_FREE:   out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
          default: begin
            out_ch.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks: change inputs at the falling edge, wait for the transfer.
  // ---------------------------------------------------------------------------

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Valid stays high when the next call follows directly.
  task automatic send_position(logic [POS_W-1:0] pos);
    @(negedge clk_i);
    in_ch.valid    <= 1'b1;
    in_ch.position <= pos;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_ch.valid    <= 1'b0;
      in_ch.position <= POS_W'($urandom);
    end
  endtask

  // Hold the sender until every predicted color has come back. Every
  // position produces a color, so nothing is left in flight after that.
  task automatic wait_for_results();
    idle_input(1);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic configure(color_t first, color_t last, logic [COLOR_W-1:0] len_word);
    wait_for_results();
    write_register(CFG_START_COLOR, first);
    write_register(CFG_END_COLOR, last);
    write_register(CFG_LINE_LENGTH, len_word);
  endtask

  // Mostly in-range positions, with endpoints and past-the-end ones mixed in.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned len, r;
    len = board.effective_length();
    r   = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return POS_W'(len - 1);
    if (r < 26) return POS_W'($urandom_range(0, MAX_LENGTH - 1));
    if (r < 32) return (len >= MAX_LENGTH) ? POS_W'(MAX_LENGTH - 1)
                                           : POS_W'($urandom_range(len, MAX_LENGTH - 1));
    return POS_W'($urandom_range(0, len - 1));
  endfunction

  function automatic color_t pick_color();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return color_t'($urandom);
    endcase
  endfunction

  // Length word: the 13-bit field at random or at an edge, upper bits random.
  function automatic logic [COLOR_W-1:0] pick_length_word();
    int unsigned        edges[10] = '{0, 1, 2, 3, 255, 257, 4095, 4096, 4097, 8191};
    logic [COLOR_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: w[LEN_W-1:0] = LEN_W'(edges[$urandom_range(0, 9)]);
      3, 4, 5: w[LEN_W-1:0] = LEN_W'($urandom_range(2, 40));
      6:       w[LEN_W-1:0] = LEN_W'($urandom_range(0, 8191));
      default: w[LEN_W-1:0] = LEN_W'($urandom_range(2, MAX_LENGTH));
    endcase
    return w;
  endfunction

  // Bursts of random length separated by random gaps, some with no gap.
  task automatic send_stream(int count);
    int sent, burst, i;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 32);
      for (i = 0; i < burst && sent < count; i++) begin
        send_position(pick_position());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 10));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    int phase, i;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: black to white over 256 positions. Cover both
    // endpoints, their neighbors, 128 next to the first midpoint, and past-the-end.
    send_position(12'd0);
    send_position(12'd255);
    send_position(12'd128);
    send_position(12'd1);
    send_position(12'd254);
    send_position(12'd256);
    send_position(12'd4095);

    // Length field of zero acts as the shortest line: only two endpoints.
    configure(32'h00FF00FF, 32'h7F00FF01, 32'hFFFF_E000);
    send_position(12'd0);
    send_position(12'd1);
    send_position(12'd2);

    // Length above the maximum clamps to 4096; the unused index is dropped.
    rx_mode   = RX_RANDOM;
    stall_pct = 40;
    configure(32'hFFFFFFFF, 32'h00000000, 32'hFFFF_FFFF);
    write_register(CFG_UNUSED_IDX, $urandom);
    send_position(12'd4095);
    send_position(12'd0);
    send_position(12'd2048);
    send_position(12'd2047);

    // Length one, then three (a single midpoint between the endpoints).
    configure(32'h12345678, 32'h9ABCDEF0, 32'h0000_0001);
    send_position(12'd1);
    send_position(12'd0);
    configure(32'h80FE01FF, 32'h01FF00FE, 32'h0000_0003);
    for (i = 0; i < 4; i++) send_position(POS_W'(i));

    // Random phases: new settings each time, different receiver behavior.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      if ($urandom_range(0, 9) < 7) write_register(CFG_START_COLOR, pick_color());
      if ($urandom_range(0, 9) < 7) write_register(CFG_END_COLOR, pick_color());
      if ($urandom_range(0, 9) == 0) write_register(CFG_UNUSED_IDX, $urandom);
      write_register(CFG_LINE_LENGTH, pick_length_word());
      rx_mode    = rx_mode_e'(phase % 3);
      rx_pattern = 16'($urandom) | 16'h0101;
      stall_pct  = $urandom_range(10, 60);
      if (phase == 2) begin
        // Long receiver hold-off while positions keep coming back to back.
        hold_requests++;
        for (i = 0; i < 40; i++) send_position(pick_position());
        send_stream(PHASE_ITEMS - 40);
      end else if (phase == 6) begin
        // Pause the sender mid-phase until everything has drained.
        send_stream(PHASE_ITEMS / 2);
        wait_for_results();
        send_stream(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        send_stream(PHASE_ITEMS);
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    board.check_leftover();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
